@@ rtl/sprite_quad_batcher_macros.svh @@
// ----------------------------------------------------------------------------
// sprite_quad_batcher_macros
// Assertion helpers used by the sprite quad batcher datapath.
// ----------------------------------------------------------------------------
`ifndef SPRITE_QUAD_BATCHER_MACROS_SVH
`define SPRITE_QUAD_BATCHER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SQB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sqb assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define SQB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sqb assertion failed");

`endif

@@ rtl/sqb_pkg.sv @@
// ----------------------------------------------------------------------------
// sqb_pkg
// Shared types and constants of the sprite quad batcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sqb_pkg;

  localparam int IN_DW  = 208;
  localparam int OUT_DW = 120;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  // radians per 1/65536 turn, Q30 scaled up by 2^16
  localparam logic [32:0] ANG_K = 33'd6746518852;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  localparam int HORNER_STEPS = 5;
  localparam int STEP_W = $clog2(HORNER_STEPS);

  localparam logic [6:0] SIN_DIV [HORNER_STEPS] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
  localparam logic [6:0] COS_DIV [HORNER_STEPS] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};

  // floor(2^32 / n): quotient estimate is low by at most one
  localparam logic [31:0] SIN_RCP [HORNER_STEPS] = '{
    32'(64'd4294967296 / 64'd110), 32'(64'd4294967296 / 64'd72),
    32'(64'd4294967296 / 64'd42),  32'(64'd4294967296 / 64'd20),
    32'(64'd4294967296 / 64'd6)};
  localparam logic [31:0] COS_RCP [HORNER_STEPS] = '{
    32'(64'd4294967296 / 64'd90), 32'(64'd4294967296 / 64'd56),
    32'(64'd4294967296 / 64'd30), 32'(64'd4294967296 / 64'd12),
    32'(64'd4294967296 / 64'd2)};

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_DECIDE, ST_ANGLE, ST_SQUARE, ST_HMUL, ST_HRECIP,
    ST_HCORR, ST_SINE, ST_QUAD, ST_PROD, ST_FLUSH, ST_VSUM, ST_VOUT
  } state_t;

  typedef enum logic [2:0] {
    TOP_NONE, TOP_ANGLE, TOP_SQUARE, TOP_HMUL, TOP_HRECIP, TOP_HCORR,
    TOP_SINE, TOP_QUAD
  } trig_op_t;

  typedef struct packed {
    logic              load_in;
    logic              scan;
    logic              commit;
    trig_op_t          trig_op;
    logic [STEP_W-1:0] step;
    logic              prod;
    logic              vsum;
    logic              emit_flush;
    logic              emit_vert;
    logic [1:0]        corner;
  } sqb_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic flush;
    logic out_free;
  } sqb_stat_t;

endpackage

@@ rtl/sqb_trig.sv @@
// ----------------------------------------------------------------------------
// sqb_trig
// Sine and cosine of a 16-bit turn angle, Q2.30, one operation per command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sqb_trig (
  input  logic                          clk,
  input  sqb_pkg::trig_op_t             op,
  input  logic [sqb_pkg::STEP_W-1:0]    step,
  input  logic [15:0]                   angle,
  output logic signed [31:0]            sin_o,
  output logic signed [31:0]            cos_o
);
  import sqb_pkg::*;

  logic [1:0]         quad_r;
  logic               swap_r;
  logic [29:0]        x_r, x2_r, vs_r, vc_r, qs_r, qc_r, sin0_r;
  logic [30:0]        hs_r, hc_r;
  logic signed [31:0] sin_r, cos_r;

  logic [13:0] rem_a, t_fold;
  logic [14:0] rem_f;
  logic        swap_c;
  logic [46:0] xp;
  logic [59:0] sq;
  logic [60:0] ps, pc, sp;
  logic [61:0] rs, rc;
  logic [30:0] rem_s, rem_c;
  logic [29:0] qs_adj, qc_adj;
  logic [30:0] s0, c0;
  logic signed [31:0] s0s, c0s;

  always_comb begin
    rem_a  = angle[13:0];
    swap_c = rem_a > 14'd8192;
    rem_f  = 15'd16384 - {1'b0, rem_a};
    t_fold = swap_c ? rem_f[13:0] : rem_a;
    xp     = 47'(t_fold) * 47'(ANG_K) + 47'd32768;
    sq     = 60'(x_r) * 60'(x_r);
    ps     = 61'(x2_r) * 61'(hs_r);
    pc     = 61'(x2_r) * 61'(hc_r);
    sp     = 61'(x_r) * 61'(hs_r);
    rs     = 62'(vs_r) * 62'(SIN_RCP[step]);
    rc     = 62'(vc_r) * 62'(COS_RCP[step]);
    rem_s  = 31'(vs_r) - 31'(qs_r) * 31'(SIN_DIV[step]);
    rem_c  = 31'(vc_r) - 31'(qc_r) * 31'(COS_DIV[step]);
    qs_adj = qs_r + 30'(rem_s >= 31'(SIN_DIV[step]));
    qc_adj = qc_r + 30'(rem_c >= 31'(COS_DIV[step]));
    s0     = swap_r ? hc_r : {1'b0, sin0_r};
    c0     = swap_r ? {1'b0, sin0_r} : hc_r;
    s0s    = $signed({1'b0, s0});
    c0s    = $signed({1'b0, c0});
  end

  always_ff @(posedge clk) begin
    unique case (op)
      TOP_ANGLE: begin
        quad_r <= angle[15:14];
        swap_r <= swap_c;
        x_r    <= xp[45:16];
      end
      TOP_SQUARE: begin
        x2_r <= sq[59:30];
        hs_r <= Q30_ONE;
        hc_r <= Q30_ONE;
      end
      TOP_HMUL: begin
        vs_r <= ps[59:30];
        vc_r <= pc[59:30];
      end
      TOP_HRECIP: begin
        qs_r <= rs[61:32];
        qc_r <= rc[61:32];
      end
      TOP_HCORR: begin
        hs_r <= Q30_ONE - {1'b0, qs_adj};
        hc_r <= Q30_ONE - {1'b0, qc_adj};
      end
      TOP_SINE: begin
        sin0_r <= sp[59:30];
      end
      TOP_QUAD: begin
        case (quad_r)
          2'd0: begin sin_r <= s0s;  cos_r <= c0s;  end
          2'd1: begin sin_r <= c0s;  cos_r <= -s0s; end
          2'd2: begin sin_r <= -s0s; cos_r <= -c0s; end
          default: begin sin_r <= -c0s; cos_r <= s0s; end
        endcase
      end
      default: ;
    endcase
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

@@ rtl/sqb_dpath.sv @@
// ----------------------------------------------------------------------------
// sqb_dpath
// Sprite registers, slot table, batch counters, vertex math, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sprite_quad_batcher_macros.svh"

module sqb_dpath #(
  parameter int MAX_QUADS  = 1024,
  parameter int SLOT_COUNT = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sqb_pkg::sqb_cmd_t            cmd,
  output sqb_pkg::sqb_stat_t           stat,
  input  logic [sqb_pkg::IN_DW-1:0]    in_tdata,
  input  logic                         in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [sqb_pkg::OUT_DW-1:0]   out_tdata,
  output logic                         out_tuser,
  output logic                         out_tlast
);
  import sqb_pkg::*;

  localparam int UW = $clog2(SLOT_COUNT + 1);
  localparam int SW = $clog2(SLOT_COUNT);
  localparam int QW = $clog2(MAX_QUADS + 1);

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -34'sd2147483648) r = 32'sh8000_0000;
    else r = 32'(v);
    return r;
  endfunction

  // sprite
  logic signed [31:0] px_r, py_r, pz_r, sx_r, sy_r;
  logic [15:0]        angle_r;
  logic               tex_r;
  logic [31:0]        id_r;

  // slot table and batch
  logic [31:0]   mem [SLOT_COUNT];
  logic [UW-1:0] slots_used_r, idx_r;
  logic [QW-1:0] quads_r;
  logic [31:0]   rd_data_r;
  logic [SW-1:0] rd_idx_r, hit_slot_r, slot_r;
  logic          rd_vld_r, hit_r, flush_r;
  logic [10:0]   bq_r;

  logic          full_c, miss_c, flush_c, mem_we;
  logic [SW-1:0] mem_wa;

  // vertex
  logic signed [31:0] sin_s, cos_s;
  logic signed [63:0] a_r, b_r, c_r, d_r;
  logic signed [63:0] tx, ty;
  logic signed [32:0] rx_r, ry_r;
  logic               sgx_pos, sgy_pos;

  // output register
  logic               ov_r, okind_r, olast_r;
  logic [1:0]         ocorner_r;
  logic signed [31:0] ovx_r, ovy_r, ovz_r;
  logic [4:0]         oslot_r;
  logic [10:0]        obq_r;

  sqb_trig u_trig (
    .clk   (clk),
    .op    (cmd.trig_op),
    .step  (cmd.step),
    .angle (angle_r),
    .sin_o (sin_s),
    .cos_o (cos_s)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      px_r    <= in_tdata[31:0];
      py_r    <= in_tdata[63:32];
      pz_r    <= in_tdata[95:64];
      angle_r <= in_tdata[111:96];
      sx_r    <= in_tdata[143:112];
      sy_r    <= in_tdata[175:144];
      id_r    <= in_tdata[207:176];
      tex_r   <= in_tuser;
    end
  end

  // linear scan of live slots, one entry per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= UW'(1);
      rd_vld_r <= 1'b0;
      hit_r    <= 1'b0;
    end else if (cmd.load_in) begin
      idx_r    <= UW'(1);
      rd_vld_r <= 1'b0;
      hit_r    <= 1'b0;
    end else if (cmd.scan) begin
      if (idx_r < slots_used_r) begin
        rd_vld_r <= 1'b1;
        idx_r    <= idx_r + UW'(1);
      end else begin
        rd_vld_r <= 1'b0;
      end
      if (rd_vld_r && !hit_r && rd_data_r == id_r) begin
        hit_r      <= 1'b1;
        hit_slot_r <= rd_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_data_r <= mem[idx_r[SW-1:0]];
      rd_idx_r  <= idx_r[SW-1:0];
    end
    if (mem_we) mem[mem_wa] <= id_r;
  end

  always_comb begin
    full_c  = quads_r >= QW'(MAX_QUADS);
    miss_c  = tex_r && !hit_r;
    flush_c = full_c || (miss_c && slots_used_r >= UW'(SLOT_COUNT));
    mem_we  = cmd.commit && tex_r && (flush_c || !hit_r);
    mem_wa  = flush_c ? SW'(1) : slots_used_r[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_used_r <= UW'(1);
      quads_r      <= '0;
    end else if (cmd.commit) begin
      // a flush restarts the batch before the slot is taken
      if (flush_c) begin
        quads_r      <= QW'(1);
        slots_used_r <= tex_r ? UW'(2) : UW'(1);
      end else begin
        quads_r <= quads_r + QW'(1);
        if (miss_c) slots_used_r <= slots_used_r + UW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      flush_r <= flush_c;
      bq_r    <= 11'(quads_r);
      if (!tex_r) slot_r <= '0;
      else if (flush_c) slot_r <= SW'(1);
      else if (hit_r) slot_r <= hit_slot_r;
      else slot_r <= slots_used_r[SW-1:0];
    end
  end

  always_comb begin
    sgx_pos = (cmd.corner == 2'd1) || (cmd.corner == 2'd2);
    sgy_pos = cmd.corner[1];
    tx = (sgx_pos ? a_r : -a_r) + (sgy_pos ? -b_r : b_r) + 64'sd1073741824;
    ty = (sgx_pos ? c_r : -c_r) + (sgy_pos ? d_r : -d_r) + 64'sd1073741824;
  end

  always_ff @(posedge clk) begin
    if (cmd.prod) begin
      a_r <= 64'(sx_r) * 64'(cos_s);
      b_r <= 64'(sy_r) * 64'(sin_s);
      c_r <= 64'(sx_r) * 64'(sin_s);
      d_r <= 64'(sy_r) * 64'(cos_s);
    end
    if (cmd.vsum) begin
      rx_r <= 33'(tx >>> 31);
      ry_r <= 33'(ty >>> 31);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.emit_flush || cmd.emit_vert) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_flush) begin
      okind_r   <= KIND_FLUSH;
      ocorner_r <= 2'd0;
      ovx_r     <= '0;
      ovy_r     <= '0;
      ovz_r     <= '0;
      oslot_r   <= '0;
      obq_r     <= bq_r;
      olast_r   <= 1'b0;
    end else if (cmd.emit_vert) begin
      okind_r   <= KIND_VERTEX;
      ocorner_r <= cmd.corner;
      ovx_r     <= sat32(34'(px_r) + 34'(rx_r));
      ovy_r     <= sat32(34'(py_r) + 34'(ry_r));
      ovz_r     <= pz_r;
      oslot_r   <= 5'(slot_r);
      obq_r     <= '0;
      olast_r   <= cmd.corner == 2'd3;
    end
  end

  assign stat.scan_done = !tex_r || (idx_r >= slots_used_r && !rd_vld_r);
  assign stat.flush     = flush_r;
  assign stat.out_free  = !ov_r || out_tready;

  assign out_tvalid = ov_r;
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {6'd0, obq_r, oslot_r, ovz_r, ovy_r, ovx_r, ocorner_r};

  `SQB_ASSERT_NOW(a_slots_range, 1'b1,
                  slots_used_r >= UW'(1) && slots_used_r <= UW'(SLOT_COUNT))
  `SQB_ASSERT_NOW(a_emit_free, cmd.emit_flush || cmd.emit_vert, !ov_r || out_tready)
  `SQB_ASSERT_NEXT(a_flush_restart, cmd.commit && flush_c,
                   quads_r == QW'(1) && slots_used_r <= UW'(2))

endmodule

@@ rtl/sqb_ctrl.sv @@
// ----------------------------------------------------------------------------
// sqb_ctrl
// Sequencer: input capture, slot scan, sine/cosine steps, result emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sqb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output sqb_pkg::sqb_cmd_t   cmd,
  input  sqb_pkg::sqb_stat_t  stat
);
  import sqb_pkg::*;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [1:0]        corner_r, corner_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      step_r   <= '0;
      corner_r <= '0;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      corner_r <= corner_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    corner_nxt = corner_r;
    cmd        = '0;
    cmd.step   = step_r;
    cmd.corner = corner_r;
    in_tready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_ANGLE;
      end
      ST_ANGLE: begin
        cmd.trig_op = TOP_ANGLE;
        step_nxt    = '0;
        state_nxt   = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd.trig_op = TOP_SQUARE;
        state_nxt   = ST_HMUL;
      end
      ST_HMUL: begin
        cmd.trig_op = TOP_HMUL;
        state_nxt   = ST_HRECIP;
      end
      ST_HRECIP: begin
        cmd.trig_op = TOP_HRECIP;
        state_nxt   = ST_HCORR;
      end
      ST_HCORR: begin
        cmd.trig_op = TOP_HCORR;
        if (step_r == STEP_W'(HORNER_STEPS - 1)) begin
          state_nxt = ST_SINE;
        end else begin
          step_nxt  = step_r + STEP_W'(1);
          state_nxt = ST_HMUL;
        end
      end
      ST_SINE: begin
        cmd.trig_op = TOP_SINE;
        state_nxt   = ST_QUAD;
      end
      ST_QUAD: begin
        cmd.trig_op = TOP_QUAD;
        state_nxt   = ST_PROD;
      end
      ST_PROD: begin
        cmd.prod   = 1'b1;
        corner_nxt = 2'd0;
        state_nxt  = stat.flush ? ST_FLUSH : ST_VSUM;
      end
      ST_FLUSH: begin
        if (stat.out_free) begin
          cmd.emit_flush = 1'b1;
          state_nxt      = ST_VSUM;
        end
      end
      ST_VSUM: begin
        cmd.vsum  = 1'b1;
        state_nxt = ST_VOUT;
      end
      ST_VOUT: begin
        // hold until the output register can take the word
        if (stat.out_free) begin
          cmd.emit_vert = 1'b1;
          if (corner_r == 2'd3) begin
            state_nxt = ST_IDLE;
          end else begin
            corner_nxt = corner_r + 2'd1;
            state_nxt  = ST_VSUM;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/sprite_quad_batcher.sv @@
// ----------------------------------------------------------------------------
// sprite_quad_batcher
// One sprite in, an optional batch flush and four transformed quad vertices out.
// ----------------------------------------------------------------------------
//   channel  dir  handshake              payload
//   in_      in   in_tvalid/in_tready    tdata sprite fields, tuser textured
//   out_     out  out_tvalid/out_tready  tdata vertex/flush fields, tuser kind,
//                                        tlast last
//
// One sprite at a time. The slot scan runs over the filled slots for textured
// sprites only; a flush adds its own step before the vertices are emitted.
// The slot scan and the five shared Horner steps of sine/cosine take most of the time.
// A new sprite is taken while the last vertex still waits in the output register.
// Output stalls hold the sequencer; rst_n empties the batch and slot table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sprite_quad_batcher #(
  parameter int MAX_QUADS  = 1024,
  parameter int SLOT_COUNT = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // pos_x, pos_y, pos_z, angle, size_x, size_y, texture_id
  input  logic [sqb_pkg::IN_DW-1:0]   in_tdata,
  // textured
  input  logic                        in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // corner, vert_x, vert_y, vert_z, tex_slot, batch_quads, zero pad
  output logic [sqb_pkg::OUT_DW-1:0]  out_tdata,
  // kind
  output logic                        out_tuser,
  output logic                        out_tlast
);
  import sqb_pkg::*;

  sqb_cmd_t  cmd;
  sqb_stat_t stat;

  sqb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  sqb_dpath #(
    .MAX_QUADS  (MAX_QUADS),
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

@@ tb/sv/sprite_quad_batcher_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_quad_batcher_checker
// Watches both channels of the batcher, predicts every flush and vertex word
// from the accepted sprites, and compares the output words in order.
// ----------------------------------------------------------------------------

module sprite_quad_batcher_checker #(
  parameter int MAX_QUADS  = 1024,
  parameter int SLOT_COUNT = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [sqb_pkg::IN_DW-1:0]   in_tdata,
  input  logic                        in_tuser,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [sqb_pkg::OUT_DW-1:0]  out_tdata,
  input  logic                        out_tuser,
  input  logic                        out_tlast,
  output int                          fail_count,
  output int                          pending
);
  import sqb_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [1:0]  corner;
    logic [31:0] vert_x;
    logic [31:0] vert_y;
    logic [31:0] vert_z;
    logic [4:0]  tex_slot;
    logic [10:0] batch_quads;
    logic        last;
  } quad_word_t;

  quad_word_t  expected_words[$];
  logic [31:0] slot_ids[SLOT_COUNT];
  int          slots_used;
  int          quads_in_batch;

  initial fail_count = 0;
  initial pending = 0;

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Taylor-style series on a folded angle of at most an eighth turn, Q30
  function automatic void series_sincos(input longint unsigned t,
                                        output longint s, output longint c);
    longint unsigned x, x2, hs, hc;
    longint unsigned sdiv[5];
    longint unsigned cdiv[5];
    sdiv = '{110, 72, 42, 20, 6};
    cdiv = '{90, 56, 30, 12, 2};
    x = (t * 64'd6746518852 + 64'd32768) >> 16;
    x2 = (x * x) >> 30;
    hs = 64'd1 << 30;
    hc = 64'd1 << 30;
    for (int i = 0; i < 5; i++) begin
      hs = (64'd1 << 30) - ((x2 * hs) >> 30) / sdiv[i];
      hc = (64'd1 << 30) - ((x2 * hc) >> 30) / cdiv[i];
    end
    s = longint'((x * hs) >> 30);
    c = longint'(hc);
  endfunction

  function automatic void angle_sincos(input logic [15:0] a,
                                       output longint s, output longint c);
    longint s0, c0;
    logic [13:0] r;
    r = a[13:0];
    if (r <= 14'd8192) series_sincos(longint'(r), s0, c0);
    else series_sincos(64'd16384 - longint'(r), c0, s0);
    case (a[15:14])
      2'd0: begin s = s0;  c = c0;  end
      2'd1: begin s = c0;  c = -s0; end
      2'd2: begin s = -s0; c = -c0; end
      default: begin s = -c0; c = s0; end
    endcase
  endfunction

  function automatic int lookup_slot(input logic [31:0] id);
    for (int i = 1; i < slots_used && i < SLOT_COUNT; i++)
      if (slot_ids[i] == id) return i;
    return 0;
  endfunction

  task automatic predict_sprite(input logic [IN_DW-1:0] d, input logic textured);
    longint     px, py, pz, sx, sy, s, c, ex, ey, rx, ry;
    logic [31:0] id;
    int         slot;
    bit         flush;
    quad_word_t w;
    px = longint'($signed(d[31:0]));
    py = longint'($signed(d[63:32]));
    pz = longint'($signed(d[95:64]));
    sx = longint'($signed(d[143:112]));
    sy = longint'($signed(d[175:144]));
    id = d[207:176];
    slot = 0;
    flush = quads_in_batch >= MAX_QUADS;
    if (textured && lookup_slot(id) == 0 && slots_used >= SLOT_COUNT) flush = 1;
    if (flush) begin
      w = '0;
      w.kind = KIND_FLUSH;
      w.batch_quads = quads_in_batch[10:0];
      expected_words.push_back(w);
      quads_in_batch = 0;
      slots_used = 1;
    end
    if (textured) begin
      slot = lookup_slot(id);
      if (slot == 0 && slots_used < SLOT_COUNT) begin
        slot = slots_used;
        slot_ids[slot] = id;
        slots_used++;
      end
    end
    angle_sincos(d[111:96], s, c);
    for (int k = 0; k < 4; k++) begin
      ex = (k == 1 || k == 2) ? sx : -sx;
      ey = (k >= 2) ? sy : -sy;
      rx = (ex * c - ey * s + (64'sd1 <<< 30)) >>> 31;
      ry = (ex * s + ey * c + (64'sd1 <<< 30)) >>> 31;
      w = '0;
      w.kind = KIND_VERTEX;
      w.corner = k[1:0];
      w.vert_x = 32'(sat32(px + rx));
      w.vert_y = 32'(sat32(py + ry));
      w.vert_z = 32'(pz);
      w.tex_slot = slot[4:0];
      w.last = (k == 3);
      expected_words.push_back(w);
    end
    quads_in_batch++;
  endtask

  always @(posedge clk) begin
    quad_word_t got, want;
    if (!rst_n) begin
      expected_words.delete();
      slots_used = 1;
      quads_in_batch = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.kind        = out_tuser;
        got.corner      = out_tdata[1:0];
        got.vert_x      = out_tdata[33:2];
        got.vert_y      = out_tdata[65:34];
        got.vert_z      = out_tdata[97:66];
        got.tex_slot    = out_tdata[102:98];
        got.batch_quads = out_tdata[113:103];
        got.last        = out_tlast;
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected output word kind=%0b corner=%0d", got.kind, got.corner);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch: expected kind=%0b corner=%0d x=%h y=%h z=%h slot=%0d bq=%0d last=%0b",
                       want.kind, want.corner, want.vert_x, want.vert_y, want.vert_z,
                       want.tex_slot, want.batch_quads, want.last);
              $display("          actual   kind=%0b corner=%0d x=%h y=%h z=%h slot=%0d bq=%0d last=%0b",
                       got.kind, got.corner, got.vert_x, got.vert_y, got.vert_z,
                       got.tex_slot, got.batch_quads, got.last);
            end
          end
        end
      end
      if (in_tvalid && in_tready) predict_sprite(in_tdata, in_tuser);
    end
    pending <= expected_words.size();
  end

endmodule

@@ tb/sv/sprite_quad_batcher_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_quad_batcher_tb
// Drives sprites into the batcher with random gaps and output stalls: corner
// cases first, then slot-table fills and random sprites.
// ----------------------------------------------------------------------------

module sprite_quad_batcher_tb;
  import sqb_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_DW-1:0]    in_tdata;
  logic                in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_DW-1:0]   out_tdata;
  logic                out_tuser;
  logic                out_tlast;
  int                  fail_count;
  int                  pending;
  int                  idle_cycles;
  bit                  calm;
  logic [31:0]         id_pool[40];

  sprite_quad_batcher dut (.*);

  sprite_quad_batcher_checker u_checker (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // hold tready low for random stretches
  initial begin
    int stall;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      stall = gap_len();
      out_tready <= 1'b0;
      repeat (stall) @(negedge clk);
      out_tready <= 1'b1;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_sprite(input logic [31:0] px, py, pz, input logic [15:0] ang,
                             input logic [31:0] sx, sy, input logic tex,
                             input logic [31:0] id);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {id, sy, sx, ang, pz, py, px};
    in_tuser  <= tex;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_random(input int tex_mode);
    logic [31:0] id;
    logic        tex;
    id  = ($urandom_range(0, 9) == 0) ? $urandom : id_pool[$urandom_range(0, 39)];
    tex = (tex_mode == 2) ? 1'($urandom_range(0, 1)) : tex_mode[0];
    send_sprite($urandom, $urandom, $urandom, 16'($urandom), $urandom_range(0, 3) == 0 ?
                $urandom : $urandom_range(0, 32'h0040_0000) - 32'h0020_0000,
                $urandom, tex, id);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    calm = 1'b0;
    foreach (id_pool[i]) id_pool[i] = $urandom;
    id_pool[0] = 32'h0;
    id_pool[1] = 32'hFFFF_FFFF;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // extremes of position, scale and angle; octant and quadrant edges
    send_sprite(32'h0, 32'h0, 32'h0, 16'd0, 32'h0001_0000, 32'h0001_0000, 1'b0, 32'h0);
    send_sprite(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd0,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    send_sprite(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'd32768,
                32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0);
    send_sprite(32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 16'd8192,
                32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'hFFFF_FFFF);
    send_sprite(32'h0001_0000, 32'hFFFF_0000, 32'h0, 16'd8193,
                32'h0002_0000, 32'h0003_0000, 1'b1, 32'h1234_5678);
    send_sprite(32'h0, 32'h0, 32'h0, 16'd16384, 32'h0001_0000, 32'h0002_0000, 1'b0,
                32'hFFFF_FFFF);
    send_sprite(32'h0, 32'h0, 32'h0, 16'd49152, 32'hFFFF_0000, 32'h0001_0000, 1'b1, 32'h0);
    send_sprite(32'h0, 32'h0, 32'h0, 16'd65535, 32'h0, 32'h0, 1'b0, 32'h0);
    send_sprite(32'h0, 32'h0, 32'h0, 16'd16383, 32'h0001_8000, 32'hFFFF_FFFF, 1'b1,
                32'h1234_5678);
    send_sprite(32'h7FFF_0000, 32'h8001_0000, 32'h0, 16'd24576,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h8000_0001);
    send_sprite(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA,
                32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 32'hAAAA_AAAA);

    // fill the slot table until a miss forces a flush
    for (int i = 0; i < 40; i++)
      send_sprite($urandom, $urandom, $urandom, 16'($urandom), $urandom, $urandom, 1'b1,
                  $urandom);

    for (int i = 0; i < 430; i++) begin
      if (i % 120 == 60) calm = ~calm;
      send_random(i % 7 == 0 ? 2 : 1);
    end
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sprite_quad_batcher.f @@
+incdir+rtl
rtl/sqb_pkg.sv
rtl/sqb_trig.sv
rtl/sqb_dpath.sv
rtl/sqb_ctrl.sv
rtl/sprite_quad_batcher.sv
tb/sv/sprite_quad_batcher_checker.sv
tb/sv/sprite_quad_batcher_tb.sv
